FILE: design/scsa_pkg.sv
// Shared constants, types and helper functions of the size-class slab allocator.
`default_nettype none

package scsa_pkg;

    localparam int NUM_SLABS          = 16;
    localparam int SLAB_BYTES         = 65536;
    localparam int NUM_CLASSES        = 7;
    localparam int MIN_BLOCK_BYTES    = 32;
    localparam int SLAB_HEADER_BYTES  = 64;
    localparam int BLOCK_HEADER_BYTES = 16;

    localparam int ADDR_W = 20;
    localparam int SIZE_W = 16;
    localparam int ST_W   = 3;
    localparam int CLS_W  = 3;
    localparam int CNT_W  = 12;
    localparam int PTR_W  = 5;
    localparam int NEED_W = 18;

    localparam int SLAB_W          = (NUM_SLABS > 1) ? $clog2(NUM_SLABS) : 1;
    localparam int SLAB_SH         = $clog2(SLAB_BYTES);
    localparam int MIN_SH          = $clog2(MIN_BLOCK_BYTES);
    localparam int BLOCKS_PER_SLAB = SLAB_BYTES / MIN_BLOCK_BYTES;
    localparam int IDX_W           = $clog2(BLOCKS_PER_SLAB);
    localparam int MEM_DEPTH       = NUM_SLABS * BLOCKS_PER_SLAB;
    localparam int MEM_AW          = SLAB_W + IDX_W;
    localparam int NUM_LISTS       = NUM_CLASSES * 3;
    localparam int LIST_W          = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam int ROOM            = SLAB_BYTES - SLAB_HEADER_BYTES;

    localparam logic [PTR_W-1:0] PTR_NULL   = 5'd31;
    localparam logic [CNT_W-1:0] STACK_NULL = 12'hFFF;

    localparam logic [1:0] KIND_EMPTY   = 2'd0;
    localparam logic [1:0] KIND_PARTIAL = 2'd1;
    localparam logic [1:0] KIND_FULL    = 2'd2;

    localparam logic [ST_W-1:0] ST_OK          = 3'd0;
    localparam logic [ST_W-1:0] ST_NO_SLAB     = 3'd1;
    localparam logic [ST_W-1:0] ST_TOO_LARGE   = 3'd2;
    localparam logic [ST_W-1:0] ST_BAD_ADDR    = 3'd3;
    localparam logic [ST_W-1:0] ST_DOUBLE_FREE = 3'd4;

    localparam int CB_0 = MIN_BLOCK_BYTES << 0;
    localparam int CB_1 = MIN_BLOCK_BYTES << 1;
    localparam int CB_2 = MIN_BLOCK_BYTES << 2;
    localparam int CB_3 = MIN_BLOCK_BYTES << 3;
    localparam int CB_4 = MIN_BLOCK_BYTES << 4;
    localparam int CB_5 = MIN_BLOCK_BYTES << 5;
    localparam int CB_6 = MIN_BLOCK_BYTES << 6;
    localparam int CB_7 = MIN_BLOCK_BYTES << 7;

    localparam logic [CNT_W-1:0] TOT_0 = CNT_W'((CB_0 > ROOM) ? 0 : ROOM / CB_0);
    localparam logic [CNT_W-1:0] TOT_1 = CNT_W'((CB_1 > ROOM) ? 0 : ROOM / CB_1);
    localparam logic [CNT_W-1:0] TOT_2 = CNT_W'((CB_2 > ROOM) ? 0 : ROOM / CB_2);
    localparam logic [CNT_W-1:0] TOT_3 = CNT_W'((CB_3 > ROOM) ? 0 : ROOM / CB_3);
    localparam logic [CNT_W-1:0] TOT_4 = CNT_W'((CB_4 > ROOM) ? 0 : ROOM / CB_4);
    localparam logic [CNT_W-1:0] TOT_5 = CNT_W'((CB_5 > ROOM) ? 0 : ROOM / CB_5);
    localparam logic [CNT_W-1:0] TOT_6 = CNT_W'((CB_6 > ROOM) ? 0 : ROOM / CB_6);
    localparam logic [CNT_W-1:0] TOT_7 = CNT_W'((CB_7 > ROOM) ? 0 : ROOM / CB_7);

    typedef struct packed {
        logic            load;
        logic            fail;
        logic [ST_W-1:0] fail_code;
        logic            alloc_dec;
        logic            sel_alloc;
        logic            claim;
        logic            take_bump;
        logic            take_stack;
        logic            alloc_commit;
        logic            free_sel;
        logic            free_commit;
        logic            rmv;
        logic            app;
        logic            done;
    } cmd_t;

    typedef struct packed {
        logic is_free;
        logic too_large;
        logic no_room;
        logic has_slab;
        logic pool_full;
        logic bad_addr;
        logic slab_full;
        logic use_stack;
        logic dbl_free;
        logic move_pend;
    } stat_t;

    function automatic logic [NEED_W-1:0] class_bytes(input logic [CLS_W-1:0] c);
        class_bytes = NEED_W'(MIN_BLOCK_BYTES) << c;
    endfunction

    function automatic logic [CNT_W-1:0] class_tot(input logic [CLS_W-1:0] c);
        case (c)
            3'd0:    class_tot = TOT_0;
            3'd1:    class_tot = TOT_1;
            3'd2:    class_tot = TOT_2;
            3'd3:    class_tot = TOT_3;
            3'd4:    class_tot = TOT_4;
            3'd5:    class_tot = TOT_5;
            3'd6:    class_tot = TOT_6;
            default: class_tot = TOT_7;
        endcase
    endfunction

    function automatic logic [LIST_W-1:0] list_idx(input logic [CLS_W-1:0] c,
                                                   input logic [1:0] kind);
        list_idx = LIST_W'(c) * LIST_W'(3) + LIST_W'(kind);
    endfunction

endpackage

`default_nettype wire

FILE: design/scsa_dpath.sv
// Datapath: request registers, slab tables, slab lists and block memory.
`default_nettype none

module scsa_dpath
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire scsa_pkg::cmd_t                cmd,
    input  wire logic                          req_type,
    input  wire logic [scsa_pkg::SIZE_W-1:0]   req_size,
    input  wire logic [scsa_pkg::ADDR_W-1:0]   free_addr,
    output scsa_pkg::stat_t                    stat,
    output logic                               done,
    output logic [scsa_pkg::ST_W-1:0]          status,
    output logic [scsa_pkg::ADDR_W-1:0]        result_addr,
    output logic [scsa_pkg::CLS_W-1:0]         size_class
);

    localparam int MW = scsa_pkg::CNT_W + 1;

    logic                            req_type_reg;
    logic [scsa_pkg::SIZE_W-1:0]     req_size_reg;
    logic [scsa_pkg::ADDR_W-1:0]     free_addr_reg;
    logic [scsa_pkg::SLAB_W-1:0]     slab_reg;
    logic [scsa_pkg::CNT_W-1:0]      idx_reg;
    logic [scsa_pkg::CLS_W-1:0]      cls_reg;
    logic [1:0]                      kind_reg;
    logic [scsa_pkg::PTR_W-1:0]      claimed_reg;
    logic [scsa_pkg::PTR_W-1:0]      head_reg [scsa_pkg::NUM_LISTS];
    logic [scsa_pkg::PTR_W-1:0]      tail_reg [scsa_pkg::NUM_LISTS];
    logic [scsa_pkg::CLS_W-1:0]      cls_of_reg [scsa_pkg::NUM_SLABS];
    logic [scsa_pkg::CNT_W-1:0]      used_reg [scsa_pkg::NUM_SLABS];
    logic [scsa_pkg::CNT_W-1:0]      bump_reg [scsa_pkg::NUM_SLABS];
    logic [scsa_pkg::CNT_W-1:0]      stk_reg [scsa_pkg::NUM_SLABS];
    logic [scsa_pkg::PTR_W-1:0]      nxt_reg [scsa_pkg::NUM_SLABS];
    logic [scsa_pkg::PTR_W-1:0]      prv_reg [scsa_pkg::NUM_SLABS];
    logic [1:0]                      kind_of_reg [scsa_pkg::NUM_SLABS];
    logic [MW-1:0]                   blk_mem [scsa_pkg::MEM_DEPTH];
    logic [MW-1:0]                   rd_reg;
    logic                            done_reg;
    logic [scsa_pkg::ST_W-1:0]       status_reg;
    logic [scsa_pkg::ADDR_W-1:0]     addr_reg;
    logic [scsa_pkg::CLS_W-1:0]      ocls_reg;

    // allocate decode
    logic [scsa_pkg::NEED_W-1:0]     need;
    logic [scsa_pkg::CLS_W-1:0]      c_alloc;
    logic                            too_large;
    logic [scsa_pkg::PTR_W-1:0]      part_head;
    logic [scsa_pkg::PTR_W-1:0]      empty_head;
    // free decode
    logic [scsa_pkg::ADDR_W-1:0]     blk;
    logic [scsa_pkg::ADDR_W-1:0]     f_s_full;
    logic [scsa_pkg::SLAB_W-1:0]     f_s;
    logic [scsa_pkg::ADDR_W-1:0]     f_off;
    logic [scsa_pkg::ADDR_W-1:0]     f_off2;
    logic [scsa_pkg::CLS_W-1:0]      f_c;
    logic [4:0]                      f_sh;
    logic [scsa_pkg::ADDR_W-1:0]     f_idx;
    logic                            f_bad;
    // current slab
    logic [scsa_pkg::CNT_W-1:0]      s_used;
    logic [scsa_pkg::CNT_W-1:0]      s_used_inc;
    logic [scsa_pkg::CNT_W-1:0]      s_used_dec;
    logic [scsa_pkg::CNT_W-1:0]      tot_cur;
    logic [scsa_pkg::CNT_W-1:0]      s_stk;
    logic [scsa_pkg::PTR_W-1:0]      s_prev;
    logic [scsa_pkg::PTR_W-1:0]      s_next;
    logic [scsa_pkg::LIST_W-1:0]     l_rm;
    logic [scsa_pkg::LIST_W-1:0]     l_ap;
    logic [1:0]                      move_kind;
    logic [scsa_pkg::MEM_AW-1:0]     mem_ra;
    logic [scsa_pkg::MEM_AW-1:0]     mem_wa;
    logic                            mem_we;
    logic [MW-1:0]                   mem_wd;
    logic [31:0]                     a_addr;

    always_comb
    begin
        need    = scsa_pkg::NEED_W'(req_size_reg)
                + scsa_pkg::NEED_W'(scsa_pkg::BLOCK_HEADER_BYTES);
        c_alloc = '0;
        for (int k = scsa_pkg::NUM_CLASSES - 1; k >= 0; k--)
        begin
            if (need <= scsa_pkg::class_bytes(scsa_pkg::CLS_W'(k)))
                c_alloc = scsa_pkg::CLS_W'(k);
        end
        too_large  = need > scsa_pkg::class_bytes(scsa_pkg::CLS_W'(scsa_pkg::NUM_CLASSES - 1));
        part_head  = head_reg[scsa_pkg::list_idx(cls_reg, scsa_pkg::KIND_PARTIAL)];
        empty_head = head_reg[scsa_pkg::list_idx(cls_reg, scsa_pkg::KIND_EMPTY)];
    end

    always_comb
    begin
        blk      = free_addr_reg - scsa_pkg::ADDR_W'(scsa_pkg::BLOCK_HEADER_BYTES);
        f_s_full = blk >> scsa_pkg::SLAB_SH;
        f_s      = f_s_full[scsa_pkg::SLAB_W-1:0];
        f_off    = blk & scsa_pkg::ADDR_W'(scsa_pkg::SLAB_BYTES - 1);
        f_off2   = f_off - scsa_pkg::ADDR_W'(scsa_pkg::SLAB_HEADER_BYTES);
        f_c      = cls_of_reg[f_s];
        f_sh     = 5'(scsa_pkg::MIN_SH) + 5'(f_c);
        f_idx    = f_off2 >> f_sh;
        f_bad    = (free_addr_reg < scsa_pkg::ADDR_W'(scsa_pkg::BLOCK_HEADER_BYTES))
                || (f_s_full >= scsa_pkg::ADDR_W'(claimed_reg))
                || (f_off < scsa_pkg::ADDR_W'(scsa_pkg::SLAB_HEADER_BYTES))
                || ((f_idx << f_sh) != f_off2)
                || (f_idx >= scsa_pkg::ADDR_W'(scsa_pkg::class_tot(f_c)))
                || (f_idx >= scsa_pkg::ADDR_W'(scsa_pkg::BLOCKS_PER_SLAB));
    end

    always_comb
    begin
        s_used     = used_reg[slab_reg];
        s_used_inc = s_used + 1'b1;
        s_used_dec = s_used - 1'b1;
        tot_cur    = scsa_pkg::class_tot(cls_reg);
        s_stk      = stk_reg[slab_reg];
        s_prev     = prv_reg[slab_reg];
        s_next     = nxt_reg[slab_reg];
        l_rm       = scsa_pkg::list_idx(cls_reg, kind_of_reg[slab_reg]);
        l_ap       = scsa_pkg::list_idx(cls_reg, kind_reg);
        if (req_type_reg)
            move_kind = (s_used_dec == '0) ? scsa_pkg::KIND_EMPTY : scsa_pkg::KIND_PARTIAL;
        else
            move_kind = (s_used_inc >= tot_cur) ? scsa_pkg::KIND_FULL : scsa_pkg::KIND_PARTIAL;

        // free reads the freed block, allocate reads the top of the free stack
        if (req_type_reg)
            mem_ra = {slab_reg, idx_reg[scsa_pkg::IDX_W-1:0]};
        else
            mem_ra = {slab_reg, s_stk[scsa_pkg::IDX_W-1:0]};
        mem_wa = {slab_reg, idx_reg[scsa_pkg::IDX_W-1:0]};
        mem_we = cmd.alloc_commit || cmd.free_commit;
        mem_wd = cmd.alloc_commit ? {1'b1, scsa_pkg::STACK_NULL} : {1'b0, s_stk};

        a_addr = (32'(slab_reg) << scsa_pkg::SLAB_SH)
               + 32'(scsa_pkg::SLAB_HEADER_BYTES)
               + (32'(idx_reg[scsa_pkg::IDX_W-1:0]) << (5'(scsa_pkg::MIN_SH) + 5'(cls_reg)))
               + 32'(scsa_pkg::BLOCK_HEADER_BYTES);
    end

    always_comb
    begin
        stat.is_free   = req_type_reg;
        stat.too_large = too_large;
        stat.no_room   = tot_cur == '0;
        stat.has_slab  = (part_head != scsa_pkg::PTR_NULL) || (empty_head != scsa_pkg::PTR_NULL);
        stat.pool_full = claimed_reg >= scsa_pkg::PTR_W'(scsa_pkg::NUM_SLABS);
        stat.bad_addr  = f_bad;
        stat.slab_full = s_used >= tot_cur;
        stat.use_stack = s_stk != scsa_pkg::STACK_NULL;
        // a block at or past the bump index was never handed out
        stat.dbl_free  = !((idx_reg < bump_reg[slab_reg]) && rd_reg[scsa_pkg::CNT_W])
                      || (s_used == '0);
        if (req_type_reg)
            stat.move_pend = (s_used_dec == '0) || ((tot_cur - s_used_dec) == 12'd1);
        else
            stat.move_pend = (s_used_inc >= tot_cur) || (s_used == '0);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            blk_mem[mem_wa] <= mem_wd;
        rd_reg <= blk_mem[mem_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            claimed_reg <= '0;
            done_reg    <= 1'b0;
            for (int i = 0; i < scsa_pkg::NUM_LISTS; i++)
            begin
                head_reg[i] <= scsa_pkg::PTR_NULL;
                tail_reg[i] <= scsa_pkg::PTR_NULL;
            end
        end
        else
        begin
            done_reg <= cmd.done;
            if (cmd.claim)
                claimed_reg <= claimed_reg + 1'b1;
            if (cmd.rmv)
            begin
                if (s_prev == scsa_pkg::PTR_NULL)
                    head_reg[l_rm] <= s_next;
                if (s_next == scsa_pkg::PTR_NULL)
                    tail_reg[l_rm] <= s_prev;
            end
            if (cmd.app)
            begin
                if (head_reg[l_ap] == scsa_pkg::PTR_NULL)
                    head_reg[l_ap] <= scsa_pkg::PTR_W'(slab_reg);
                tail_reg[l_ap] <= scsa_pkg::PTR_W'(slab_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_type_reg  <= req_type;
            req_size_reg  <= req_size;
            free_addr_reg <= free_addr;
            status_reg    <= scsa_pkg::ST_OK;
            addr_reg      <= '0;
            ocls_reg      <= '0;
        end
        if (cmd.fail)
            status_reg <= cmd.fail_code;
        if (cmd.alloc_dec)
        begin
            cls_reg  <= c_alloc;
            ocls_reg <= too_large ? '0 : c_alloc;
        end
        if (cmd.sel_alloc)
            slab_reg <= (part_head != scsa_pkg::PTR_NULL) ? part_head[scsa_pkg::SLAB_W-1:0]
                                                          : empty_head[scsa_pkg::SLAB_W-1:0];
        if (cmd.claim)
        begin
            slab_reg                                       <= claimed_reg[scsa_pkg::SLAB_W-1:0];
            cls_of_reg[claimed_reg[scsa_pkg::SLAB_W-1:0]]  <= cls_reg;
            used_reg[claimed_reg[scsa_pkg::SLAB_W-1:0]]    <= '0;
            bump_reg[claimed_reg[scsa_pkg::SLAB_W-1:0]]    <= '0;
            stk_reg[claimed_reg[scsa_pkg::SLAB_W-1:0]]     <= scsa_pkg::STACK_NULL;
            kind_reg                                       <= scsa_pkg::KIND_EMPTY;
        end
        if (cmd.take_bump)
        begin
            idx_reg            <= bump_reg[slab_reg];
            bump_reg[slab_reg] <= bump_reg[slab_reg] + 1'b1;
        end
        if (cmd.take_stack)
        begin
            idx_reg           <= s_stk;
            stk_reg[slab_reg] <= rd_reg[scsa_pkg::CNT_W-1:0];
        end
        if (cmd.alloc_commit)
        begin
            used_reg[slab_reg] <= s_used_inc;
            addr_reg           <= a_addr[scsa_pkg::ADDR_W-1:0];
            kind_reg           <= move_kind;
        end
        if (cmd.free_sel)
        begin
            slab_reg <= f_s;
            idx_reg  <= scsa_pkg::CNT_W'(f_idx);
            cls_reg  <= f_c;
        end
        if (cmd.free_commit)
        begin
            stk_reg[slab_reg]  <= idx_reg;
            used_reg[slab_reg] <= s_used_dec;
            ocls_reg           <= cls_reg;
            kind_reg           <= move_kind;
        end
        if (cmd.rmv)
        begin
            if (s_prev != scsa_pkg::PTR_NULL)
                nxt_reg[s_prev[scsa_pkg::SLAB_W-1:0]] <= s_next;
            if (s_next != scsa_pkg::PTR_NULL)
                prv_reg[s_next[scsa_pkg::SLAB_W-1:0]] <= s_prev;
        end
        if (cmd.app)
        begin
            nxt_reg[slab_reg]     <= scsa_pkg::PTR_NULL;
            prv_reg[slab_reg]     <= tail_reg[l_ap];
            kind_of_reg[slab_reg] <= kind_reg;
            if (head_reg[l_ap] != scsa_pkg::PTR_NULL)
                nxt_reg[tail_reg[l_ap][scsa_pkg::SLAB_W-1:0]] <= scsa_pkg::PTR_W'(slab_reg);
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign result_addr = addr_reg;
    assign size_class  = ocls_reg;

endmodule

`default_nettype wire

FILE: design/scsa_ctrl.sv
// Controller: request sequencing state machine.
`default_nettype none

module scsa_ctrl
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire scsa_pkg::stat_t  stat,
    output logic                  busy,
    output scsa_pkg::cmd_t        cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DEC  = 4'd1;
    localparam logic [3:0] ST_ASEL = 4'd2;
    localparam logic [3:0] ST_CAPP = 4'd3;
    localparam logic [3:0] ST_CHK  = 4'd4;
    localparam logic [3:0] ST_APOP = 4'd5;
    localparam logic [3:0] ST_ACOM = 4'd6;
    localparam logic [3:0] ST_FRD  = 4'd7;
    localparam logic [3:0] ST_FCHK = 4'd8;
    localparam logic [3:0] ST_RMV  = 4'd9;
    localparam logic [3:0] ST_MAPP = 4'd10;
    localparam logic [3:0] ST_DONE = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DEC;
                end
            end
            ST_DEC:
            begin
                if (stat.is_free)
                begin
                    if (stat.bad_addr)
                    begin
                        cmd.fail      = 1'b1;
                        cmd.fail_code = scsa_pkg::ST_BAD_ADDR;
                        state_next    = ST_DONE;
                    end
                    else
                    begin
                        cmd.free_sel = 1'b1;
                        state_next   = ST_FRD;
                    end
                end
                else
                begin
                    cmd.alloc_dec = 1'b1;
                    if (stat.too_large)
                    begin
                        cmd.fail      = 1'b1;
                        cmd.fail_code = scsa_pkg::ST_TOO_LARGE;
                        state_next    = ST_DONE;
                    end
                    else
                        state_next = ST_ASEL;
                end
            end
            ST_ASEL:
            begin
                if (stat.no_room)
                begin
                    cmd.fail      = 1'b1;
                    cmd.fail_code = scsa_pkg::ST_NO_SLAB;
                    state_next    = ST_DONE;
                end
                else if (stat.has_slab)
                begin
                    cmd.sel_alloc = 1'b1;
                    state_next    = ST_CHK;
                end
                else if (stat.pool_full)
                begin
                    cmd.fail      = 1'b1;
                    cmd.fail_code = scsa_pkg::ST_NO_SLAB;
                    state_next    = ST_DONE;
                end
                else
                begin
                    cmd.claim  = 1'b1;
                    state_next = ST_CAPP;
                end
            end
            ST_CAPP:
            begin
                cmd.app    = 1'b1;
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (stat.slab_full)
                begin
                    cmd.fail      = 1'b1;
                    cmd.fail_code = scsa_pkg::ST_NO_SLAB;
                    state_next    = ST_DONE;
                end
                else if (stat.use_stack)
                    state_next = ST_APOP;
                else
                begin
                    cmd.take_bump = 1'b1;
                    state_next    = ST_ACOM;
                end
            end
            ST_APOP:
            begin
                cmd.take_stack = 1'b1;
                state_next     = ST_ACOM;
            end
            ST_ACOM:
            begin
                cmd.alloc_commit = 1'b1;
                state_next       = stat.move_pend ? ST_RMV : ST_DONE;
            end
            ST_FRD:
            begin
                state_next = ST_FCHK;
            end
            ST_FCHK:
            begin
                if (stat.dbl_free)
                begin
                    cmd.fail      = 1'b1;
                    cmd.fail_code = scsa_pkg::ST_DOUBLE_FREE;
                    state_next    = ST_DONE;
                end
                else
                begin
                    cmd.free_commit = 1'b1;
                    state_next      = stat.move_pend ? ST_RMV : ST_DONE;
                end
            end
            ST_RMV:
            begin
                cmd.rmv    = 1'b1;
                state_next = ST_MAPP;
            end
            ST_MAPP:
            begin
                cmd.app    = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                cmd.done   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = state_reg != ST_IDLE;

`ifndef SYNTHESIS
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy && state_reg == ST_DEC)
        else $error("accepted request did not start decode");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.done |=> !busy)
        else $error("controller not idle after result");
    a_one_update: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.rmv, cmd.app, cmd.alloc_commit, cmd.free_commit, cmd.claim}))
        else $error("conflicting table updates");
    a_commit_move: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.alloc_commit || cmd.free_commit) && stat.move_pend |=> cmd.rmv)
        else $error("list move skipped after commit");
`endif

endmodule

`default_nettype wire

FILE: design/size_class_slab_allocator_top.sv
// Top level of the size-class slab allocator: controller plus datapath.
//
//  channel   | ports                                   | transfer
//  ----------+-----------------------------------------+---------------------------
//  request   | start, busy, req_type, req_size,        | start high while busy low
//            | free_addr                               |
//  result    | done, status, result_addr, size_class   | done high, one cycle
//
// Sequencing: one request per transfer. Too large and bad address fail at decode,
// out of slabs at slab selection or the fullness check, double free after the
// block memory read; the longest walk is an allocate that pops the free stack or
// claims a slab and then moves the slab to another list. The controller walks
// dependent reads and writes of the slab tables, the block memory read and the
// list move. busy falls with the result strobe, so the next transfer can be taken
// at the edge that ends it.
// Reset: rst_n clears the controller, the slab count and the list heads and
// tails; block state is qualified by each slab's bump index instead of being
// cleared, so no clearing pass is needed.
// Stalls: busy stays high until the result strobe; the receiver cannot stall.
`default_nettype none

module size_class_slab_allocator_top
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          req_type,
    input  wire logic [scsa_pkg::SIZE_W-1:0]   req_size,
    input  wire logic [scsa_pkg::ADDR_W-1:0]   free_addr,
    output logic                               done,
    output logic [scsa_pkg::ST_W-1:0]          status,
    output logic [scsa_pkg::ADDR_W-1:0]        result_addr,
    output logic [scsa_pkg::CLS_W-1:0]         size_class
);

    // command and status between the state machine and the datapath
    scsa_pkg::cmd_t  cmd;
    scsa_pkg::stat_t stat;

    scsa_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    scsa_dpath u_dpath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .req_type    (req_type),
        .req_size    (req_size),
        .free_addr   (free_addr),
        .stat        (stat),
        .done        (done),
        .status      (status),
        .result_addr (result_addr),
        .size_class  (size_class)
    );

endmodule

`default_nettype wire
